// ----- design/ofi_pkg.sv -----
`timescale 1ns / 1ps

package ofi_pkg;

  // Book depth and field widths
  localparam int Levels    = 5;
  localparam int PriceBits = 32;
  localparam int QtyBits   = 32;
  localparam int LevelBits = 3;
  localparam int SumBits   = 37;

  // Index into the per-level store
  localparam int LvlIdxBits = (Levels > 1) ? $clog2(Levels) : 1;

  // One side's signed quantity change
  localparam int DeltaBits = QtyBits + 1;

  // Accumulator headroom before saturation
  localparam int AccBits = ((SumBits > QtyBits + 2) ? SumBits : QtyBits + 2) + 1;

endpackage

// ----- design/order_flow_imbalance.sv -----
`timescale 1ns / 1ps
// A snapshot's sum passes from its last level in the input register to the result register, and
// is offered on the output from there until it transfers.
// Throughput: one level per cycle; the per-level store is read and written in the compute cycle.
// A last level waits in the input register only while an earlier sum is still not taken.
// Reset (rst_ni low, asynchronous): both stages empty, all stored levels absent, sum cleared.

module order_flow_imbalance (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ofi_pkg::LevelBits-1:0]          level_i,
  input  logic [ofi_pkg::PriceBits-1:0]          bid_price_i,
  input  logic [ofi_pkg::QtyBits-1:0]            bid_qty_i,
  input  logic                                   bid_valid_i,
  input  logic [ofi_pkg::PriceBits-1:0]          ask_price_i,
  input  logic [ofi_pkg::QtyBits-1:0]            ask_qty_i,
  input  logic                                   ask_valid_i,
  input  logic                                   last_level_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ofi_pkg::SumBits-1:0]     imbalance_o
);

  localparam int PB  = ofi_pkg::PriceBits;
  localparam int QB  = ofi_pkg::QtyBits;
  localparam int DB  = ofi_pkg::DeltaBits;
  localparam int AB  = ofi_pkg::AccBits;
  localparam int SB  = ofi_pkg::SumBits;
  localparam int LIB = ofi_pkg::LvlIdxBits;

  // Saturation limits of the running sum, widened to the accumulator
  localparam logic signed [AB-1:0] SumMax = AB'(signed'({1'b0, {(SB-1){1'b1}}}));
  localparam logic signed [AB-1:0] SumMin = AB'(signed'({1'b1, {(SB-1){1'b0}}}));

  // Quantity change on one side; improve means the price became more aggressive
  function automatic logic signed [DB-1:0] side_delta(
    input logic          pv,
    input logic [QB-1:0] pq,
    input logic          cv,
    input logic [QB-1:0] cq,
    input logic          same,
    input logic          improve
  );
    logic signed [DB-1:0] pqs;
    logic signed [DB-1:0] cqs;
    pqs = signed'({1'b0, pq});
    cqs = signed'({1'b0, cq});
    priority if (!pv && !cv) begin
      return '0;
    end else if (!pv) begin
      return cqs;
    end else if (!cv) begin
      return -pqs;
    end else if (same) begin
      return cqs - pqs;
    end else if (improve) begin
      return cqs;
    end else begin
      return -pqs;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input register: hold one level until the compute cycle can take it
  // ---------------------------------------------------------------------------
  logic                          s1_valid_q, s1_valid_d;
  logic [ofi_pkg::LevelBits-1:0] level_q;
  logic [PB-1:0]                 bid_price_q, ask_price_q;
  logic [QB-1:0]                 bid_qty_q, ask_qty_q;
  logic                          bid_valid_q, ask_valid_q, last_q;

  logic s1_fire;
  logic in_xfer;
  logic out_valid_q, out_valid_d;

  // A non-last level only updates state, so it never waits on the output side
  assign s1_fire    = s1_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      level_q     <= level_i;
      bid_price_q <= bid_price_i;
      bid_qty_q   <= bid_qty_i;
      bid_valid_q <= bid_valid_i;
      ask_price_q <= ask_price_i;
      ask_qty_q   <= ask_qty_i;
      ask_valid_q <= ask_valid_i;
      last_q      <= last_level_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Previous snapshot, one entry per level. Valid bits reset; prices and
  // quantities are only looked at once their level has been seen.
  // ---------------------------------------------------------------------------
  logic [PB-1:0] prev_bid_price_q [ofi_pkg::Levels];
  logic [QB-1:0] prev_bid_qty_q   [ofi_pkg::Levels];
  logic [PB-1:0] prev_ask_price_q [ofi_pkg::Levels];
  logic [QB-1:0] prev_ask_qty_q   [ofi_pkg::Levels];
  logic [ofi_pkg::Levels-1:0] prev_bid_valid_q, prev_ask_valid_q;

  logic           lvl_ok;
  logic [LIB-1:0] idx;
  logic           wr_en;

  // Levels beyond the book depth add nothing and store nothing
  assign lvl_ok = 32'(level_q) < ofi_pkg::Levels;
  assign idx    = LIB'(level_q);
  assign wr_en  = s1_fire && lvl_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bid_valid_q <= '0;
      prev_ask_valid_q <= '0;
    end else if (wr_en) begin
      prev_bid_valid_q[idx] <= bid_valid_q;
      prev_ask_valid_q[idx] <= ask_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prev_bid_price_q[idx] <= bid_price_q;
      prev_bid_qty_q[idx]   <= bid_qty_q;
      prev_ask_price_q[idx] <= ask_price_q;
      prev_ask_qty_q[idx]   <= ask_qty_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-level delta and saturating accumulate
  // ---------------------------------------------------------------------------
  logic [PB-1:0] pbp, pap;
  logic [QB-1:0] pbq, paq;
  logic          pbv, pav;
  logic signed [DB-1:0] db, da;
  logic signed [AB-1:0] d, acc, acc_sat;
  logic signed [SB-1:0] sum_q, sum_d, base;
  logic signed [SB-1:0] out_imb_q;

  always_comb begin
    pbp = prev_bid_price_q[idx];
    pbq = prev_bid_qty_q[idx];
    pap = prev_ask_price_q[idx];
    paq = prev_ask_qty_q[idx];
    pbv = lvl_ok && prev_bid_valid_q[idx];
    pav = lvl_ok && prev_ask_valid_q[idx];

    // Bid improves on a higher price, ask on a lower one
    db = side_delta(pbv, pbq, bid_valid_q, bid_qty_q,
                    bid_price_q == pbp, bid_price_q > pbp);
    da = side_delta(pav, paq, ask_valid_q, ask_qty_q,
                    ask_price_q == pap, ask_price_q < pap);
    d   = AB'(db) - AB'(da);
    acc = AB'(sum_q) + d;

    priority if (acc > SumMax) begin
      acc_sat = SumMax;
    end else if (acc < SumMin) begin
      acc_sat = SumMin;
    end else begin
      acc_sat = acc;
    end

    base  = lvl_ok ? SB'(acc_sat) : sum_q;
    sum_d = sum_q;
    if (s1_fire) begin
      // The last level closes the snapshot: emit and clear
      sum_d = last_q ? '0 : base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold the sum until its transfer
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && last_q) begin
      out_imb_q <= base;
    end
  end

  assign out_valid_o = out_valid_q;
  assign imbalance_o = out_imb_q;

endmodule

// ----- design/ofi_checker.sv -----
`timescale 1ns / 1ps

module ofi_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               last_level_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [ofi_pkg::SumBits-1:0] imbalance_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(imbalance_o))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // A fresh result is preceded by the transfer of a last level into the input register
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_level_i, 2))
    else $error("result without a closing level");

endmodule

bind order_flow_imbalance ofi_checker u_ofi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_level_i (last_level_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .imbalance_o  (imbalance_o)
);
